/* sv/sphpf_pkg.sv */
package sphpf_pkg;

  // particle store depth and index widths
  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  // field widths
  localparam int COORD_W = 24;

  // divider chain: dividend/quotient width and divisor width
  localparam int DIV_W = 64;
  localparam int DEN_W = 24;

  // one stored particle
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] pressure;
    logic [COORD_W-1:0]        density;
  } particle_t;

  // state carried from one divider cell to the next
  typedef struct packed {
    logic             valid;
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] work;
    logic [DEN_W-1:0] den;
  } div_cell_t;

  // divider request and response
  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             valid;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

/* sv/sphpf_div_cell.sv */
module sphpf_div_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sphpf_pkg::div_cell_t  cell_in,
  output sphpf_pkg::div_cell_t  cell_out
);
  import sphpf_pkg::*;

  logic [DEN_W:0] trial;
  logic           fits;
  div_cell_t      cell_nxt;
  div_cell_t      cell_r;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial          = {cell_in.rem, cell_in.work[DIV_W-1]};
    fits           = (trial >= {1'b0, cell_in.den});
    cell_nxt.valid = cell_in.valid;
    cell_nxt.den   = cell_in.den;
    cell_nxt.rem   = fits ? DEN_W'(trial - {1'b0, cell_in.den}) : trial[DEN_W-1:0];
    cell_nxt.work  = {cell_in.work[DIV_W-2:0], fits};
  end

  // hand over to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

endmodule

/* sv/sphpf_div_chain.sv */
module sphpf_div_chain (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sphpf_pkg::div_req_t  req,
  output sphpf_pkg::div_rsp_t  rsp
);
  import sphpf_pkg::*;

  div_cell_t link [DIV_W+1];

  // dividend enters the work register, remainder starts at zero
  always_comb begin
    link[0].valid = req.valid;
    link[0].rem   = '0;
    link[0].work  = req.num;
    link[0].den   = req.den;
  end

  // one cell per quotient bit
  for (genvar g = 0; g < DIV_W; g++) begin : g_cell
    sphpf_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (link[g]),
      .cell_out (link[g+1])
    );
  end

  assign rsp.valid = link[DIV_W].valid;
  assign rsp.quo   = link[DIV_W].work;

endmodule

/* sv/sphpf_store.sv */
module sphpf_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [sphpf_pkg::IDX_W-1:0] wr_addr,
  input  sphpf_pkg::particle_t        wr_data,
  input  logic [sphpf_pkg::IDX_W-1:0] rd_addr,
  output sphpf_pkg::particle_t        rd_data
);
  import sphpf_pkg::*;

  particle_t mem [MAX_PARTICLES];
  particle_t rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/sph_pressure_force_unit.sv */
// SPH pressure force unit. Clear (command 0) and load (command 1) transactions
// return nothing; a load into a full store of 64 particles returns one result
// with out_overflow set. A compute transaction (command 2) returns one force per
// stored particle in load order, the final one flagged by out_last. Each pair is
// worked through by a sequencer around one 32x32 multiplier, a 2-bit-per-cycle square
// root and a 64-cell restoring divider chain with one division in flight; a pair
// inside the radius needs six divisions, which dominate its work. New transactions
// are taken only when the unit is idle; configuration writes are always ready.
module sph_pressure_force_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [23:0] in_pressure_in,
  input  logic [23:0]        in_density_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y,
  output logic signed [31:0] out_force_z,
  output logic [5:0]         out_particle_index,
  output logic               out_last,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);
  import sphpf_pkg::*;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_MASS   = 1'b1;
  localparam logic [23:0] RADIUS_RST = 24'd12800;
  localparam logic [23:0] MASS_RST   = 24'd256;

  localparam int DIFF_W = COORD_W + 1;
  localparam int D2_W   = 2 * COORD_W + 2;
  localparam int DIST_W = COORD_W + 1;
  localparam int MAC_W  = 88;
  localparam int FACC_W = 48;
  localparam int U_W    = 16;
  localparam int G_W    = 40;
  localparam int PT_W   = 40;
  localparam int MP_W   = 48;
  localparam int K_W    = 39;
  localparam logic [MAC_W-33:0] KCAP = (MAC_W-32)'(1) << 38;
  localparam logic [D2_W-1:0] SQ_ONE = D2_W'(1) << (D2_W - 2);
  localparam logic signed [FACC_W-1:0] F_MAX = FACC_W'(64'sd2147483647);
  localparam logic signed [FACC_W-1:0] F_MIN = FACC_W'(-64'sd2147483648);

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_OVF, S_RD_I, S_LAT_I, S_RD_J, S_LAT_J, S_SQ, S_SQ_LD, S_SQRT, S_CHK,
    S_U_ISS, S_U_WAIT, S_UU, S_G_ISS, S_G_WAIT, S_PT_ISS, S_PT_WAIT, S_MP, S_MP_LD,
    S_K, S_K_LD, S_TM, S_TD_ISS, S_TD_WAIT, S_NEXT_J, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [23:0]      radius_r, mass_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] i_r, j_r;
  logic [1:0]       c_r;
  logic [2:0]       mstep_r;

  particle_t        pi_r;
  particle_t        st_rd_data, st_wr_data;
  logic             st_wr_en;
  logic [IDX_W-1:0] st_rd_addr;

  logic [23:0]      dmag_r [3];
  logic [2:0]       dneg_r;
  logic [DIFF_W-1:0] pmag_r;
  logic             pneg_r;
  logic [23:0]      rho_r;

  logic signed [DIFF_W-1:0] diff [3];
  logic signed [DIFF_W-1:0] psum;

  logic [D2_W-1:0]   sq_n_r, sq_res_r, sq_one_r, sq_sum;
  logic              sq_ge;
  logic [DIST_W-1:0] dist_r;

  logic [U_W-1:0]  u_r;
  logic [G_W-1:0]  g_r;
  logic [PT_W-1:0] pt_r;
  logic [MP_W-1:0] mp_r;
  logic [K_W-1:0]  k_r;

  logic [31:0]      mul_a, mul_b;
  logic [1:0]       mul_sh;
  logic [2:0]       mul_steps;
  logic [63:0]      prod_r;
  logic             pv_r;
  logic [1:0]       psh_r;
  logic [MAC_W-1:0] acc_r, acc_add;

  logic signed [FACC_W-1:0] f_r [3];
  logic signed [FACC_W-1:0] term;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic accept, out_free, last_row, last_col;

  logic               out_valid_r;
  logic signed [31:0] out_fx_r, out_fy_r, out_fz_r;
  logic [5:0]         out_idx_r;
  logic               out_last_r, out_ovf_r;

  function automatic logic signed [31:0] sat_force(input logic signed [FACC_W-1:0] v);
    logic signed [FACC_W-1:0] s;
    s = v;
    if (v > F_MAX) s = F_MAX;
    if (v < F_MIN) s = F_MIN;
    return s[31:0];
  endfunction

  // handshake helpers
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign last_row  = (CNT_W'(i_r) + CNT_W'(1) == cnt_r);
  assign last_col  = (CNT_W'(j_r) + CNT_W'(1) == cnt_r);

  // particle store
  assign st_wr_en        = accept && (in_command == CMD_LOAD) &&
                           (cnt_r != CNT_W'(MAX_PARTICLES));
  assign st_wr_data.x        = in_pos_x;
  assign st_wr_data.y        = in_pos_y;
  assign st_wr_data.z        = in_pos_z;
  assign st_wr_data.pressure = in_pressure_in;
  assign st_wr_data.density  = in_density_in;
  assign st_rd_addr      = (state_r == S_RD_I) ? i_r : j_r;

  sphpf_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // divider chain
  sphpf_div_chain u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_req.valid = 1'b0;
    div_req.num   = '0;
    div_req.den   = radius_r;
    case (state_r)
      S_U_ISS: begin
        div_req.valid = 1'b1;
        div_req.num   = DIV_W'({radius_r - dist_r[23:0], 16'b0});
      end
      S_G_ISS: begin
        div_req.valid = 1'b1;
        div_req.num   = DIV_W'({acc_r[31:0], 8'b0});
      end
      S_PT_ISS: begin
        div_req.valid = 1'b1;
        div_req.num   = DIV_W'({pmag_r, 15'b0});
        div_req.den   = rho_r;
      end
      S_TD_ISS: begin
        div_req.valid = 1'b1;
        div_req.num   = acc_r[DIV_W-1:0];
        div_req.den   = dist_r[23:0];
      end
      default: ;
    endcase
  end

  // pair differences from the i particle and the store read
  always_comb begin
    diff[0] = DIFF_W'(pi_r.x) - DIFF_W'(st_rd_data.x);
    diff[1] = DIFF_W'(pi_r.y) - DIFF_W'(st_rd_data.y);
    diff[2] = DIFF_W'(pi_r.z) - DIFF_W'(st_rd_data.z);
    psum    = DIFF_W'(pi_r.pressure) + DIFF_W'(st_rd_data.pressure);
  end

  // square root step
  assign sq_sum = sq_res_r + sq_one_r;
  assign sq_ge  = (sq_n_r >= sq_sum);

  // multiplier operand selection per partial product
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = SH_0;
    mul_steps = 3'd0;
    case (state_r)
      S_SQ: begin
        mul_steps = 3'd3;
        case (mstep_r)
          3'd0: begin
            mul_a = 32'(dmag_r[0]);
            mul_b = 32'(dmag_r[0]);
          end
          3'd1: begin
            mul_a = 32'(dmag_r[1]);
            mul_b = 32'(dmag_r[1]);
          end
          default: begin
            mul_a = 32'(dmag_r[2]);
            mul_b = 32'(dmag_r[2]);
          end
        endcase
      end
      S_UU: begin
        mul_steps = 3'd1;
        mul_a     = 32'(u_r);
        mul_b     = 32'(u_r);
      end
      S_MP: begin
        mul_steps = 3'd2;
        mul_a     = 32'(mass_r);
        if (mstep_r == 3'd0) begin
          mul_b = pt_r[31:0];
        end else begin
          mul_b  = 32'(pt_r[PT_W-1:32]);
          mul_sh = SH_32;
        end
      end
      S_K: begin
        mul_steps = 3'd4;
        case (mstep_r)
          3'd0: begin
            mul_a = mp_r[31:0];
            mul_b = g_r[31:0];
          end
          3'd1: begin
            mul_a  = mp_r[31:0];
            mul_b  = 32'(g_r[G_W-1:32]);
            mul_sh = SH_32;
          end
          3'd2: begin
            mul_a  = 32'(mp_r[MP_W-1:32]);
            mul_b  = g_r[31:0];
            mul_sh = SH_32;
          end
          default: begin
            mul_a  = 32'(mp_r[MP_W-1:32]);
            mul_b  = 32'(g_r[G_W-1:32]);
            mul_sh = SH_64;
          end
        endcase
      end
      S_TM: begin
        mul_steps = 3'd2;
        case (c_r)
          2'd0:    mul_b = 32'(dmag_r[0]);
          2'd1:    mul_b = 32'(dmag_r[1]);
          default: mul_b = 32'(dmag_r[2]);
        endcase
        if (mstep_r == 3'd0) begin
          mul_a = k_r[31:0];
        end else begin
          mul_a  = 32'(k_r[K_W-1:32]);
          mul_sh = SH_32;
        end
      end
      default: ;
    endcase
  end

  // shifted partial product for the accumulator
  always_comb begin
    case (psh_r)
      SH_0:    acc_add = MAC_W'(prod_r);
      SH_32:   acc_add = MAC_W'(prod_r) << 32;
      default: acc_add = MAC_W'(prod_r) << 64;
    endcase
  end

  // force term magnitude from the quotient; its sign is applied when it is added
  assign term = FACC_W'(div_rsp.quo[K_W-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_LOAD: begin
              if (cnt_r == CNT_W'(MAX_PARTICLES)) state_nxt = S_OVF;
            end
            CMD_COMPUTE: begin
              if (cnt_r != '0) state_nxt = S_RD_I;
            end
            default: ;
          endcase
        end
      end
      S_OVF:     if (out_free) state_nxt = S_IDLE;
      S_RD_I:    state_nxt = S_LAT_I;
      S_LAT_I:   state_nxt = S_RD_J;
      S_RD_J:    state_nxt = (j_r == i_r) ? S_NEXT_J : S_LAT_J;
      S_LAT_J:   state_nxt = S_SQ;
      S_SQ:      if (mstep_r == mul_steps) state_nxt = S_SQ_LD;
      S_SQ_LD:   state_nxt = S_SQRT;
      S_SQRT:    if (sq_one_r == '0) state_nxt = S_CHK;
      S_CHK: begin
        if (dist_r == '0 || dist_r >= {1'b0, radius_r}) state_nxt = S_NEXT_J;
        else state_nxt = S_U_ISS;
      end
      S_U_ISS:   state_nxt = S_U_WAIT;
      S_U_WAIT:  if (div_rsp.valid) state_nxt = S_UU;
      S_UU:      if (mstep_r == mul_steps) state_nxt = S_G_ISS;
      S_G_ISS:   state_nxt = S_G_WAIT;
      S_G_WAIT:  if (div_rsp.valid) state_nxt = S_PT_ISS;
      S_PT_ISS:  state_nxt = S_PT_WAIT;
      S_PT_WAIT: if (div_rsp.valid) state_nxt = S_MP;
      S_MP:      if (mstep_r == mul_steps) state_nxt = S_MP_LD;
      S_MP_LD:   state_nxt = S_K;
      S_K:       if (mstep_r == mul_steps) state_nxt = S_K_LD;
      S_K_LD:    state_nxt = S_TM;
      S_TM:      if (mstep_r == mul_steps) state_nxt = S_TD_ISS;
      S_TD_ISS:  state_nxt = S_TD_WAIT;
      S_TD_WAIT: begin
        if (div_rsp.valid) state_nxt = (c_r == 2'd2) ? S_NEXT_J : S_TM;
      end
      S_NEXT_J:  state_nxt = last_col ? S_EMIT : S_RD_J;
      S_EMIT: begin
        if (out_free) state_nxt = last_row ? S_IDLE : S_RD_I;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      radius_r    <= RADIUS_RST;
      mass_r      <= MASS_RST;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      mstep_r     <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_data;
          CFG_MASS:   mass_r   <= cfg_data;
          default: ;
        endcase
      end

      if (accept && in_command == CMD_CLEAR) cnt_r <= '0;
      if (st_wr_en) cnt_r <= cnt_r + CNT_W'(1);

      pv_r <= (mul_steps != 3'd0) && (mstep_r < mul_steps);
      if (mul_steps != 3'd0 && mstep_r != mul_steps) mstep_r <= mstep_r + 3'd1;
      else mstep_r <= '0;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if ((state_r == S_OVF || state_r == S_EMIT) && out_free) out_valid_r <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == S_OVF && out_free) begin
      out_fx_r   <= '0;
      out_fy_r   <= '0;
      out_fz_r   <= '0;
      out_idx_r  <= '0;
      out_last_r <= 1'b0;
      out_ovf_r  <= 1'b1;
    end else if (state_r == S_EMIT && out_free) begin
      out_fx_r   <= sat_force(f_r[0]);
      out_fy_r   <= sat_force(f_r[1]);
      out_fz_r   <= sat_force(f_r[2]);
      out_idx_r  <= 6'(i_r);
      out_last_r <= last_row;
      out_ovf_r  <= 1'b0;
    end
  end

  // multiplier and accumulator
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    psh_r  <= mul_sh;
    if (mul_steps != 3'd0 && mstep_r == 3'd0) acc_r <= '0;
    else if (pv_r) acc_r <= acc_r + acc_add;
  end

  // pair datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        i_r <= '0;
        j_r <= '0;
      end
      S_LAT_I: begin
        pi_r <= st_rd_data;
        j_r  <= '0;
        f_r[0] <= '0;
        f_r[1] <= '0;
        f_r[2] <= '0;
      end
      S_LAT_J: begin
        for (int c = 0; c < 3; c++) begin
          dneg_r[c] <= diff[c][DIFF_W-1];
          dmag_r[c] <= diff[c][DIFF_W-1] ? 24'(-diff[c]) : diff[c][23:0];
        end
        pneg_r <= psum[DIFF_W-1];
        pmag_r <= psum[DIFF_W-1] ? DIFF_W'(-psum) : DIFF_W'(psum);
        rho_r  <= (st_rd_data.density == '0) ? 24'd1 : st_rd_data.density;
        c_r    <= '0;
      end
      S_SQ_LD: begin
        sq_n_r   <= acc_r[D2_W-1:0];
        sq_res_r <= '0;
        sq_one_r <= SQ_ONE;
      end
      S_SQRT: begin
        if (sq_one_r == '0) begin
          dist_r <= sq_res_r[DIST_W-1:0];
        end else begin
          if (sq_ge) begin
            sq_n_r   <= sq_n_r - sq_sum;
            sq_res_r <= (sq_res_r >> 1) + sq_one_r;
          end else begin
            sq_res_r <= sq_res_r >> 1;
          end
          sq_one_r <= sq_one_r >> 2;
        end
      end
      S_U_WAIT:  if (div_rsp.valid) u_r  <= div_rsp.quo[U_W-1:0];
      S_G_WAIT:  if (div_rsp.valid) g_r  <= div_rsp.quo[G_W-1:0];
      S_PT_WAIT: if (div_rsp.valid) pt_r <= div_rsp.quo[PT_W-1:0];
      S_MP_LD:   mp_r <= acc_r[16+MP_W-1:16];
      S_K_LD: begin
        k_r <= (acc_r[MAC_W-1:32] > KCAP) ? KCAP[K_W-1:0] : acc_r[32+K_W-1:32];
      end
      S_TD_WAIT: begin
        if (div_rsp.valid) begin
          if (pneg_r ^ dneg_r[c_r]) f_r[c_r] <= f_r[c_r] - term;
          else f_r[c_r] <= f_r[c_r] + term;
          c_r <= c_r + 2'd1;
        end
      end
      S_NEXT_J: if (!last_col) j_r <= j_r + IDX_W'(1);
      S_EMIT:   if (out_free && !last_row) i_r <= i_r + IDX_W'(1);
      default: ;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_force_x        = out_fx_r;
  assign out_force_y        = out_fy_r;
  assign out_force_z        = out_fz_r;
  assign out_particle_index = out_idx_r;
  assign out_last           = out_last_r;
  assign out_overflow       = out_ovf_r;

  // fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PARTICLES))
    else $error("particle count beyond store depth");

  // a quotient only comes back while the sequencer waits for one
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.valid |-> (state_r == S_U_WAIT || state_r == S_G_WAIT ||
                       state_r == S_PT_WAIT || state_r == S_TD_WAIT))
    else $error("divider result with no pending division");

  // pair indices stay inside the filled part of the store during compute
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_OVF) |->
      (CNT_W'(i_r) < cnt_r && CNT_W'(j_r) < cnt_r))
    else $error("pair index beyond particle count");

  // a finished row leaves a result behind
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid_r)
    else $error("force result not registered");

endmodule

/* bench/tb_sph_pressure_force_unit.sv */
module tb_sph_pressure_force_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sphpf_pkg::*;

  // command and register codes
  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic       REG_RADIUS  = 1'b0;
  localparam logic       REG_MASS    = 1'b1;
  localparam longint unsigned K_CAP  = 64'd1 << 38;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic [5:0]         idx;
    logic               last;
    logic               ovf;
  } force_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_CLEAR;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [23:0] in_pos_z = '0;
  logic signed [23:0] in_pressure_in = '0;
  logic [23:0]        in_density_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_force_x;
  logic signed [31:0] out_force_y;
  logic signed [31:0] out_force_z;
  logic [5:0]         out_particle_index;
  logic               out_last;
  logic               out_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_RADIUS;
  logic [23:0]        cfg_data = '0;

  // predictor state
  particle_t          particles [MAX_PARTICLES];
  int                 stored_count = 0;
  logic [23:0]        radius = 24'd12800;
  logic [23:0]        mass = 24'd256;
  force_t             pending_forces [$];
  int                 error_count = 0;
  int                 burst_left = 0;
  int unsigned        stall_cnt = 0;

  sph_pressure_force_unit i_dut (.*);

  always #2 clk = ~clk;

  // integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > n) one >>= 2;
    while (one != 0) begin
      if (n >= res + one) begin
        n -= res + one;
        res = (res >> 1) + one;
      end else begin
        res >>= 1;
      end
      one >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // one signed force component of a pair
  function automatic longint comp_term(longint unsigned k, longint dc,
                                       longint unsigned pair_dist, bit neg);
    logic [127:0]    prod;
    longint unsigned m;
    prod = 128'(k) * 128'(dc < 0 ? -dc : dc);
    m = 64'(prod / 128'(pair_dist));
    return (neg ^ (dc < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // expected forces of a compute over the current store
  task automatic predict_forces();
    longint          fx, fy, fz, dx, dy, dz, psum;
    longint unsigned d2, pair_dist, u, g, pt, mp, k, rho, h, pmag;
    logic [127:0]    prod;
    force_t          f;
    h = radius;
    for (int i = 0; i < stored_count; i++) begin
      fx = 0; fy = 0; fz = 0;
      for (int j = 0; j < stored_count; j++) begin
        if (j == i) continue;
        dx = longint'(particles[i].x) - longint'(particles[j].x);
        dy = longint'(particles[i].y) - longint'(particles[j].y);
        dz = longint'(particles[i].z) - longint'(particles[j].z);
        d2 = dx * dx + dy * dy + dz * dz;
        pair_dist = isqrt(d2);
        if (pair_dist == 0 || pair_dist >= h) continue;
        u = ((h - pair_dist) << 16) / h;
        g = (u * u * 256) / h;
        psum = longint'(particles[i].pressure) + longint'(particles[j].pressure);
        pmag = psum < 0 ? -psum : psum;
        rho = particles[j].density == 0 ? 1 : particles[j].density;
        pt = (pmag << 15) / rho;
        prod = 128'(mass) * 128'(pt);
        mp = 64'(prod >> 16);
        prod = (128'(mp) * 128'(g)) >> 32;
        k = prod > 128'(K_CAP) ? K_CAP : 64'(prod);
        fx += comp_term(k, dx, pair_dist, psum < 0);
        fy += comp_term(k, dy, pair_dist, psum < 0);
        fz += comp_term(k, dz, pair_dist, psum < 0);
      end
      f.fx = sat32(fx);
      f.fy = sat32(fy);
      f.fz = sat32(fz);
      f.idx = 6'(i);
      f.last = (i + 1 == stored_count);
      f.ovf = 1'b0;
      pending_forces = {pending_forces, f};
    end
  endtask

  // model effect of one accepted transaction
  task automatic predict_command(logic [1:0] cmd, particle_t p);
    force_t f;
    case (cmd)
      CMD_CLEAR: stored_count = 0;
      CMD_LOAD: begin
        if (stored_count >= MAX_PARTICLES) begin
          f = '0;
          f.ovf = 1'b1;
          pending_forces = {pending_forces, f};
        end else begin
          particles[stored_count] = p;
          stored_count++;
        end
      end
      CMD_COMPUTE: predict_forces();
      default: ;
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // send one input transaction, with bursts and gaps
  task automatic send(logic [1:0] cmd, particle_t p);
    int gap;
    bit acc;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_pos_z <= p.z;
    in_pressure_in <= p.pressure;
    in_density_in <= p.density;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    predict_command(cmd, p);
  endtask

  task automatic send_cmd(logic [1:0] cmd);
    particle_t p;
    p.x = 24'($urandom);
    p.y = 24'($urandom);
    p.z = 24'($urandom);
    p.pressure = 24'($urandom);
    p.density = 24'($urandom);
    send(cmd, p);
  endtask

  task automatic load(int x, int y, int z, int pr, int rho);
    particle_t p;
    p.x = 24'(x);
    p.y = 24'(y);
    p.z = 24'(z);
    p.pressure = 24'(pr);
    p.density = 24'(rho);
    send(CMD_LOAD, p);
  endtask

  // wait until every expected force has arrived and the unit settles
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [23:0] data);
    bit acc;
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      acc = cfg_ready;
      @(posedge clk);
    end while (!acc);
    cfg_valid <= 1'b0;
    if (idx == REG_RADIUS) radius = data;
    else mass = data;
  endtask

  // a small cluster of particles within a given spread per axis, then compute
  task automatic cluster_compute(int n, int spread);
    int cx, cy, cz;
    cx = $urandom_range(0, 16000000) - 8000000;
    cy = $urandom_range(0, 16000000) - 8000000;
    cz = $urandom_range(0, 16000000) - 8000000;
    send_cmd(CMD_CLEAR);
    for (int i = 0; i < n; i++)
      load(cx + $urandom_range(0, spread), cy + $urandom_range(0, spread),
           cz + $urandom_range(0, spread), int'($urandom_range(0, 16777215)) - 8388608,
           $urandom_range(1, 16777215) >> $urandom_range(0, 23));
    send_cmd(CMD_COMPUTE);
  endtask

  // default registers, plain pair and triple
  task automatic test_basic();
    send_cmd(CMD_CLEAR);
    load(0, 0, 0, 256, 256);
    load(2560, 0, 0, 512, 256);
    send_cmd(CMD_COMPUTE);
    load(0, -3000, 1000, -700, 300);
    send_cmd(CMD_COMPUTE);
  endtask

  // zero density, coincident particles, no-result commands, empty store
  task automatic test_special_cases();
    send_cmd(CMD_CLEAR);
    send_cmd(CMD_COMPUTE);
    send_cmd(CMD_UNUSED);
    load(100, 100, 100, 1000, 0);
    load(100, 100, 100, 1000, 0);
    load(900, -400, 300, -2000, 0);
    send_cmd(CMD_COMPUTE);
    cfg_write(REG_RADIUS, 24'd1);
    send_cmd(CMD_COMPUTE);
    cfg_write(REG_RADIUS, 24'd12800);
  endtask

  // field extremes and saturated sums
  task automatic test_extremes();
    cfg_write(REG_RADIUS, 24'hffffff);
    cfg_write(REG_MASS, 24'hffffff);
    send_cmd(CMD_CLEAR);
    load(-8388608, -8388608, -8388608, 8388607, 1);
    load(8388607, 8388607, 8388607, 8388607, 1);
    load(0, 0, 0, -8388608, 24'hffffff);
    load(1, 0, 0, -8388608, 1);
    load(0, 1, 1, -8388608, 1);
    send_cmd(CMD_COMPUTE);
    cfg_write(REG_MASS, 24'd0);
    send_cmd(CMD_COMPUTE);
    cfg_write(REG_MASS, 24'd256);
    cfg_write(REG_RADIUS, 24'd12800);
  endtask

  // fill the store, drop one load, compute over the full store
  task automatic test_full_store();
    send_cmd(CMD_CLEAR);
    for (int i = 0; i < MAX_PARTICLES; i++)
      load(-8000000 + i * 250000, i * 1000, -i * 1000, i * 100, 256 + i);
    load(0, 0, 0, 0, 1);
    drain();
    send_cmd(CMD_COMPUTE);
  endtask

  // random register settings, clusters with random content, some noise
  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      cfg_write(REG_RADIUS, phase == 0 ? 24'd12800 : 24'($urandom_range(1, 200000)));
      cfg_write(REG_MASS, 24'($urandom_range(0, 16777215) >> $urandom_range(0, 16)));
      for (int s = 0; s < 3; s++) begin
        cluster_compute($urandom_range(2, 6), int'(radius) + int'(radius >> 2));
        if ($urandom_range(0, 2) == 0) begin
          send_cmd(CMD_UNUSED);
          load(int'($urandom) >> 8, int'($urandom) >> 8, int'($urandom) >> 8,
               int'($urandom) >> 8, $urandom_range(0, 16777215));
          send_cmd(CMD_COMPUTE);
        end
      end
    end
  endtask

  // receiver stall pattern: the stall density follows a slow free-running counter
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= $urandom_range(0, 7) < stall_cnt[12:10] % 6;
  end

  // compare each result transaction with the oldest expectation
  always @(negedge clk) begin
    force_t f;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_forces.size() == 0) begin
        report("unexpected result, index", out_particle_index, -1);
      end else begin
        f = pending_forces.pop_front();
        if (out_force_x !== f.fx) report("force_x", out_force_x, f.fx);
        if (out_force_y !== f.fy) report("force_y", out_force_y, f.fy);
        if (out_force_z !== f.fz) report("force_z", out_force_z, f.fz);
        if (out_particle_index !== f.idx) report("particle_index", out_particle_index, f.idx);
        if (out_last !== f.last) report("last", out_last, f.last);
        if (out_overflow !== f.ovf) report("overflow", out_overflow, f.ovf);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic();
    test_special_cases();
    test_extremes();
    test_full_store();
    test_random();
    drain();
    if (error_count == 0 && pending_forces.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
